/* rtl/kpc_pkg.sv */
package kpc_pkg;

  // Key byte values that mark a held key
  localparam logic [7:0] KEY_LOW  = 8'h04;
  localparam logic [7:0] KEY_HIGH = 8'h40;

  // Event codes
  localparam logic [3:0] EV_NONE  = 4'd0;
  localparam logic [3:0] EV_KEY1  = 4'd1;
  localparam logic [3:0] EV_KEY2  = 4'd2;
  localparam logic [3:0] EV_KEY3  = 4'd3;
  localparam logic [3:0] EV_KEY4  = 4'd4;
  localparam logic [3:0] EV_KEY5  = 4'd5;
  localparam logic [3:0] EV_KEY6  = 4'd6;
  localparam logic [3:0] EV_KEY7  = 4'd7;
  localparam logic [3:0] EV_KEY8  = 4'd8;
  localparam logic [3:0] EV_LONG5 = 4'd9;
  localparam logic [3:0] EV_LONG3 = 4'd10;
  localparam logic [3:0] EV_LONG4 = 4'd11;
  localparam logic [3:0] EV_LONG1 = 4'd12;

  // Long keys in scan order: key 1, key 3, key 4, key 5
  localparam int NUM_LONG = 4;
  localparam logic [3:0] LK_SHORT_CODE [NUM_LONG] = '{EV_KEY1, EV_KEY3, EV_KEY4, EV_KEY5};
  localparam logic [3:0] LK_LONG_CODE  [NUM_LONG] = '{EV_LONG1, EV_LONG3, EV_LONG4, EV_LONG5};

  // Configuration register indexes
  localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
  localparam logic [1:0] REG_REPEAT_START = 2'd1;
  localparam logic [1:0] REG_REPEAT_GAP   = 2'd2;

  // Configuration reset values
  localparam logic [7:0] LONG_PRESS_RST   = 8'd200;
  localparam logic [7:0] REPEAT_START_RST = 8'd220;
  localparam logic [7:0] REPEAT_GAP_RST   = 8'd15;

  typedef struct packed {
    logic [7:0] long_press_ticks;
    logic [7:0] repeat_start_ticks;
    logic [7:0] repeat_gap;
  } cfg_t;

endpackage

/* rtl/kpc_keys.sv */
module kpc_keys (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       scan_byte0,
  input  logic [7:0]       scan_byte1,
  input  logic [7:0]       scan_byte2,
  input  logic [7:0]       scan_byte3,
  input  kpc_pkg::cfg_t    cfg,
  output logic [3:0]       event_code
);
  import kpc_pkg::*;

  // Long keys: count, armed short event, lock
  logic [7:0] lk_cnt_r  [NUM_LONG];
  logic [7:0] lk_cnt_nxt[NUM_LONG];
  logic [7:0] lk_inc    [NUM_LONG];
  logic [NUM_LONG-1:0] lk_pend_r, lk_pend_nxt;
  logic [NUM_LONG-1:0] lk_lock_r, lk_lock_nxt;
  logic [NUM_LONG-1:0] lk_held, lk_fire;
  logic [3:0]          lk_code [NUM_LONG];

  // Edge keys: key 2, key 8
  logic [1:0] ek_lock_r, ek_lock_nxt;
  logic [1:0] ek_held, ek_fire;

  // Repeat keys: key 6, key 7
  logic [7:0] rk_cnt_r  [2];
  logic [7:0] rk_cnt_nxt[2];
  logic [7:0] rk_inc1   [2];
  logic [7:0] rk_inc2   [2];
  logic [1:0] rk_pend_r, rk_pend_nxt;
  logic [1:0] rk_act_r, rk_act_nxt;
  logic [1:0] rk_held, rk_fire;

  // Decode held keys from the scan bytes
  assign lk_held[0] = (scan_byte0 == KEY_LOW);
  assign lk_held[1] = (scan_byte1 == KEY_LOW);
  assign lk_held[2] = (scan_byte1 == KEY_HIGH);
  assign lk_held[3] = (scan_byte2 == KEY_LOW);
  assign ek_held[0] = (scan_byte0 == KEY_HIGH);
  assign ek_held[1] = (scan_byte3 == KEY_HIGH);
  assign rk_held[0] = (scan_byte2 == KEY_HIGH);
  assign rk_held[1] = (scan_byte3 == KEY_LOW);

  // Long keys: short on release, long at threshold then lock
  always_comb begin
    for (int i = 0; i < NUM_LONG; i++) begin
      lk_inc[i]      = lk_cnt_r[i] + 8'd1;
      lk_cnt_nxt[i]  = lk_cnt_r[i];
      lk_pend_nxt[i] = lk_pend_r[i];
      lk_lock_nxt[i] = lk_lock_r[i];
      lk_fire[i]     = 1'b0;
      lk_code[i]     = LK_SHORT_CODE[i];
      if (!lk_held[i]) begin
        lk_lock_nxt[i] = 1'b0;
        lk_cnt_nxt[i]  = 8'd0;
        if (lk_pend_r[i]) begin
          lk_pend_nxt[i] = 1'b0;
          lk_fire[i]     = 1'b1;
        end
      end else if (!lk_lock_r[i]) begin
        lk_cnt_nxt[i]  = lk_inc[i];
        lk_pend_nxt[i] = 1'b1;
        if (lk_inc[i] >= cfg.long_press_ticks) begin
          lk_pend_nxt[i] = 1'b0;
          lk_lock_nxt[i] = 1'b1;
          lk_cnt_nxt[i]  = 8'd0;
          lk_fire[i]     = 1'b1;
          lk_code[i]     = LK_LONG_CODE[i];
        end
      end
    end
  end

  // Edge keys: fire on press, lock until release
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      ek_fire[i]     = ek_held[i] && !ek_lock_r[i];
      ek_lock_nxt[i] = ek_held[i];
    end
  end

  // Repeat keys: short on release, double-step count while repeating
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rk_inc1[i]     = rk_cnt_r[i] + 8'd1;
      rk_inc2[i]     = rk_inc1[i] + 8'd1;
      rk_cnt_nxt[i]  = rk_cnt_r[i];
      rk_pend_nxt[i] = rk_pend_r[i];
      rk_act_nxt[i]  = rk_act_r[i];
      rk_fire[i]     = 1'b0;
      if (!rk_held[i]) begin
        rk_cnt_nxt[i] = 8'd0;
        rk_act_nxt[i] = 1'b0;
        if (rk_pend_r[i]) begin
          rk_pend_nxt[i] = 1'b0;
          rk_fire[i]     = 1'b1;
        end
      end else begin
        rk_pend_nxt[i] = 1'b1;
        rk_cnt_nxt[i]  = rk_inc1[i];
        if ((rk_inc1[i] > cfg.repeat_start_ticks) || rk_act_r[i]) begin
          rk_act_nxt[i] = 1'b1;
          rk_cnt_nxt[i] = rk_inc2[i];
          if (rk_inc2[i] > cfg.repeat_gap) begin
            rk_cnt_nxt[i] = 8'd0;
            rk_fire[i]    = 1'b1;
          end
        end
      end
    end
  end

  // Pick the event of the last key in order that fired
  always_comb begin
    event_code = EV_NONE;
    if (lk_fire[0]) event_code = lk_code[0];
    if (ek_fire[0]) event_code = EV_KEY2;
    if (lk_fire[1]) event_code = lk_code[1];
    if (lk_fire[2]) event_code = lk_code[2];
    if (lk_fire[3]) event_code = lk_code[3];
    if (rk_fire[0]) event_code = EV_KEY6;
    if (rk_fire[1]) event_code = EV_KEY7;
    if (ek_fire[1]) event_code = EV_KEY8;
  end

  // Advance key state once per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LONG; i++) lk_cnt_r[i] <= 8'd0;
      for (int i = 0; i < 2; i++) rk_cnt_r[i] <= 8'd0;
      lk_pend_r <= '0;
      lk_lock_r <= '0;
      ek_lock_r <= '0;
      rk_pend_r <= '0;
      rk_act_r  <= '0;
    end else if (step) begin
      for (int i = 0; i < NUM_LONG; i++) lk_cnt_r[i] <= lk_cnt_nxt[i];
      for (int i = 0; i < 2; i++) rk_cnt_r[i] <= rk_cnt_nxt[i];
      lk_pend_r <= lk_pend_nxt;
      lk_lock_r <= lk_lock_nxt;
      ek_lock_r <= ek_lock_nxt;
      rk_pend_r <= rk_pend_nxt;
      rk_act_r  <= rk_act_nxt;
    end
  end

endmodule

/* rtl/keypad_press_classifier.sv */
// Each input transaction passes through the input register, then the result
// register; key classification sits between the two.
// Throughput: one transaction per cycle while out_ready is high; while a result
// waits, the input register can still take one transaction.
// Reset: synchronous active-low rst_n clears all key state and both stages,
// and loads the thresholds with 200, 220 and 15.
module keypad_press_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_scan_byte0,
  input  logic [7:0] in_scan_byte1,
  input  logic [7:0] in_scan_byte2,
  input  logic [7:0] in_scan_byte3,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_event_code,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);
  import kpc_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte0_r, s1_byte1_r, s1_byte2_r, s1_byte3_r;
  logic       out_valid_r, out_valid_nxt;
  logic [3:0] out_code_r;
  logic [3:0] event_code;
  logic       in_fire, advance;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_LONG_PRESS:   cfg_nxt.long_press_ticks   = cfg_wdata;
        REG_REPEAT_START: cfg_nxt.repeat_start_ticks = cfg_wdata;
        REG_REPEAT_GAP:   cfg_nxt.repeat_gap         = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks   <= LONG_PRESS_RST;
      cfg_r.repeat_start_ticks <= REPEAT_START_RST;
      cfg_r.repeat_gap         <= REPEAT_GAP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshake: move the staged transaction when the result register frees
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold input payload and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte0_r <= in_scan_byte0;
      s1_byte1_r <= in_scan_byte1;
      s1_byte2_r <= in_scan_byte2;
      s1_byte3_r <= in_scan_byte3;
    end
    if (advance) out_code_r <= event_code;
  end

  kpc_keys u_keys (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .scan_byte0 (s1_byte0_r),
    .scan_byte1 (s1_byte1_r),
    .scan_byte2 (s1_byte2_r),
    .scan_byte3 (s1_byte3_r),
    .cfg        (cfg_r),
    .event_code (event_code)
  );

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

endmodule

/* verif/keypad_press_classifier_test.sv */
`timescale 1ns / 1ps

module keypad_press_classifier_test;
  import kpc_pkg::*;

  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          SETTLE_CYCLES  = 4;
  localparam logic [1:0]  REG_SPARE      = 2'd3;

  // Key slots for hold counts and short-press flags
  localparam int SLOT_K1 = 0;
  localparam int SLOT_K3 = 1;
  localparam int SLOT_K4 = 2;
  localparam int SLOT_K5 = 3;
  localparam int SLOT_K6 = 4;
  localparam int SLOT_K7 = 5;
  // Lock slots of the edge keys follow the four long keys
  localparam int LOCK_K2 = 4;
  localparam int LOCK_K8 = 5;
  // Repeat slots
  localparam int REP_K6 = 0;
  localparam int REP_K7 = 1;

  typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_t;

  // Config rows carry long press, repeat start and repeat gap in byte0..byte2
  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic       typed;
    logic [3:0] code;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_scan_byte0 = 8'h00;
  logic [7:0] in_scan_byte1 = 8'h00;
  logic [7:0] in_scan_byte2 = 8'h00;
  logic [7:0] in_scan_byte3 = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_event_code;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_addr = REG_LONG_PRESS;
  logic [7:0] cfg_wdata = 8'h00;

  // Directed expectation travels with the transaction
  logic       item_typed = 1'b0;
  logic [3:0] item_code = EV_NONE;

  // Key tracker state and its copy of the thresholds
  logic [7:0] hold_cnt [6];
  logic       short_arm [6];
  logic       key_lock [6];
  logic       rep_on [2];
  logic [7:0] lim_long = LONG_PRESS_RST;
  logic [7:0] lim_rep  = REPEAT_START_RST;
  logic [7:0] lim_gap  = REPEAT_GAP_RST;

  logic [3:0] expected_events [$];
  logic [3:0] model_code;
  logic [3:0] oldest_code;
  stim_row_t  directed_rows [$];
  int         errors = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  int         idle_cycles = 0;
  logic [8:0] stall_phase = '0;

  keypad_press_classifier i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_scan_byte0  (in_scan_byte0),
    .in_scan_byte1  (in_scan_byte1),
    .in_scan_byte2  (in_scan_byte2),
    .in_scan_byte3  (in_scan_byte3),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_code (out_event_code),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Long keys: short code on release, long code at threshold, then lock
  function automatic logic [3:0] long_step(input int slot, input logic held,
                                           input logic [3:0] short_code,
                                           input logic [3:0] long_code,
                                           input logic [3:0] code);
    logic [3:0] result;
    result = code;
    if (!held) begin
      key_lock[slot] = 1'b0;
      hold_cnt[slot] = 8'h00;
      if (short_arm[slot]) begin
        short_arm[slot] = 1'b0;
        result = short_code;
      end
    end else if (!key_lock[slot]) begin
      hold_cnt[slot] = hold_cnt[slot] + 8'd1;
      short_arm[slot] = 1'b1;
      if (hold_cnt[slot] >= lim_long) begin
        short_arm[slot] = 1'b0;
        key_lock[slot] = 1'b1;
        hold_cnt[slot] = 8'h00;
        result = long_code;
      end
    end
    return result;
  endfunction

  // Edge keys: fire on press, lock until release
  function automatic logic [3:0] edge_step(input int slot, input logic held,
                                           input logic [3:0] key_code,
                                           input logic [3:0] code);
    logic [3:0] result;
    result = code;
    if (held && !key_lock[slot]) begin
      result = key_code;
      key_lock[slot] = 1'b1;
    end else if (!held) begin
      key_lock[slot] = 1'b0;
    end
    return result;
  endfunction

  // Repeat keys: count twice per tick once repeating, fire above the gap
  function automatic logic [3:0] repeat_step(input int slot, input int rslot,
                                             input logic held,
                                             input logic [3:0] key_code,
                                             input logic [3:0] code);
    logic [3:0] result;
    result = code;
    if (!held) begin
      hold_cnt[slot] = 8'h00;
      rep_on[rslot] = 1'b0;
      if (short_arm[slot]) begin
        short_arm[slot] = 1'b0;
        result = key_code;
      end
    end else begin
      hold_cnt[slot] = hold_cnt[slot] + 8'd1;
      short_arm[slot] = 1'b1;
      if (hold_cnt[slot] > lim_rep || rep_on[rslot]) begin
        rep_on[rslot] = 1'b1;
        hold_cnt[slot] = hold_cnt[slot] + 8'd1;
        if (hold_cnt[slot] > lim_gap) begin
          hold_cnt[slot] = 8'h00;
          result = key_code;
        end
      end
    end
    return result;
  endfunction

  // One scan tick: walk keys 1..8, the last key to fire wins
  function automatic logic [3:0] classify_tick(input logic [7:0] s0, input logic [7:0] s1,
                                               input logic [7:0] s2, input logic [7:0] s3);
    logic [3:0] code;
    code = EV_NONE;
    code = long_step(SLOT_K1, s0 == KEY_LOW, EV_KEY1, EV_LONG1, code);
    code = edge_step(LOCK_K2, s0 == KEY_HIGH, EV_KEY2, code);
    code = long_step(SLOT_K3, s1 == KEY_LOW, EV_KEY3, EV_LONG3, code);
    code = long_step(SLOT_K4, s1 == KEY_HIGH, EV_KEY4, EV_LONG4, code);
    code = long_step(SLOT_K5, s2 == KEY_LOW, EV_KEY5, EV_LONG5, code);
    code = repeat_step(SLOT_K6, REP_K6, s2 == KEY_HIGH, EV_KEY6, code);
    code = repeat_step(SLOT_K7, REP_K7, s3 == KEY_LOW, EV_KEY7, code);
    code = edge_step(LOCK_K8, s3 == KEY_HIGH, EV_KEY8, code);
    return code;
  endfunction

  // Check results against the oldest expectation, then predict new transactions
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          $error("event_code: expected nothing, actual %0d", out_event_code);
          errors++;
        end else begin
          oldest_code = expected_events.pop_front();
          if (out_event_code !== oldest_code) begin
            $error("event_code: expected %0d, actual %0d", oldest_code, out_event_code);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        model_code = classify_tick(in_scan_byte0, in_scan_byte1, in_scan_byte2, in_scan_byte3);
        expected_events.push_back(item_typed ? item_code : model_code);
      end
    end
  end

  // Receiver: rotate through always ready, random stalls and sparse acceptance
  always @(posedge clk) begin
    stall_phase <= stall_phase + 9'd1;
    case (stall_phase[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 1) == 0);
      2'd2: out_ready <= (stall_phase[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic stim_row_t scan_row(input logic [7:0] s0, input logic [7:0] s1,
                                         input logic [7:0] s2, input logic [7:0] s3,
                                         input logic typed, input logic [3:0] code);
    return '{ROW_SCAN, s0, s1, s2, s3, typed, code};
  endfunction

  function automatic stim_row_t cfg_row(input logic [7:0] lp, input logic [7:0] rs,
                                        input logic [7:0] rg);
    return '{ROW_CFG, lp, rs, rg, 8'h00, 1'b0, EV_NONE};
  endfunction

  function automatic logic [7:0] key_byte();
    logic [7:0] value;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: value = KEY_LOW;
      4, 5, 6, 7: value = KEY_HIGH;
      8: value = 8'h00;
      default: value = 8'($urandom_range(0, 255));
    endcase
    return value;
  endfunction

  // Drive one scan tick, hold it until accepted, then pace the next burst
  task automatic push_scan(input logic [7:0] s0, input logic [7:0] s1,
                           input logic [7:0] s2, input logic [7:0] s3,
                           input logic typed, input logic [3:0] code);
    int gap;
    in_valid <= 1'b1;
    in_scan_byte0 <= s0;
    in_scan_byte1 <= s1;
    in_scan_byte2 <= s2;
    in_scan_byte3 <= s3;
    item_typed <= typed;
    item_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every expected result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all thresholds plus the unused index while the block is idle
  task automatic load_thresholds(input logic [7:0] lp, input logic [7:0] rs,
                                 input logic [7:0] rg);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_addr <= REG_LONG_PRESS;
    cfg_wdata <= lp;
    @(posedge clk);
    cfg_addr <= REG_REPEAT_START;
    cfg_wdata <= rs;
    @(posedge clk);
    cfg_addr <= REG_REPEAT_GAP;
    cfg_wdata <= rg;
    @(posedge clk);
    cfg_addr <= REG_SPARE;
    cfg_wdata <= 8'($urandom_range(0, 255));
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_long = lp;
    lim_rep = rs;
    lim_gap = rg;
  endtask

  // Random hold sequences with occasional noise ticks and broken holds
  task automatic run_phase(input logic [7:0] lp, input logic [7:0] rs, input logic [7:0] rg,
                           input int n_items, input int lo_hold, input int hi_hold);
    int start;
    int hold;
    logic broken;
    logic [7:0] pick [4];
    logic [7:0] tick [4];
    load_thresholds(lp, rs, rg);
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 299) == 0) wait_drain();
      if ($urandom_range(0, 4) == 0) begin
        push_scan(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, EV_NONE);
      end else begin
        for (int i = 0; i < 4; i++) pick[i] = key_byte();
        hold = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
                                           : $urandom_range(lo_hold, hi_hold);
        broken = ($urandom_range(0, 7) == 0);
        for (int t = 0; t < hold && items_sent - start < n_items; t++) begin
          for (int i = 0; i < 4; i++) begin
            tick[i] = (broken && $urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                            : pick[i];
          end
          push_scan(tick[0], tick[1], tick[2], tick[3], 1'b0, EV_NONE);
        end
        // release most keys, keep some held into the next sequence
        for (int i = 0; i < 4; i++) tick[i] = ($urandom_range(0, 3) == 0) ? pick[i] : 8'h00;
        push_scan(tick[0], tick[1], tick[2], tick[3], 1'b0, EV_NONE);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) begin
      hold_cnt[i] = 8'h00;
      short_arm[i] = 1'b0;
      key_lock[i] = 1'b0;
    end
    rep_on[REP_K6] = 1'b0;
    rep_on[REP_K7] = 1'b0;

    // Reset thresholds: singles, releases in order, last-key-wins, edge keys
    directed_rows.push_back(scan_row(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, EV_NONE));
    directed_rows.push_back(scan_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, EV_NONE));
    directed_rows.push_back(scan_row(KEY_HIGH, 8'h00, 8'h00, 8'h00, 1'b1, EV_KEY2));
    directed_rows.push_back(scan_row(KEY_HIGH, 8'h00, 8'h00, 8'h00, 1'b1, EV_NONE));
    directed_rows.push_back(scan_row(8'h00, 8'h00, 8'h00, KEY_HIGH, 1'b1, EV_KEY8));
    directed_rows.push_back(scan_row(KEY_LOW, KEY_LOW, KEY_LOW, KEY_LOW, 1'b1, EV_NONE));
    directed_rows.push_back(scan_row(8'h00, KEY_LOW, KEY_LOW, KEY_LOW, 1'b1, EV_KEY1));
    directed_rows.push_back(scan_row(8'h00, 8'h00, KEY_LOW, KEY_LOW, 1'b1, EV_KEY3));
    directed_rows.push_back(scan_row(8'h00, 8'h00, 8'h00, KEY_LOW, 1'b1, EV_KEY5));
    directed_rows.push_back(scan_row(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, EV_KEY7));
    directed_rows.push_back(scan_row(8'h00, KEY_HIGH, KEY_HIGH, 8'h00, 1'b1, EV_NONE));
    directed_rows.push_back(scan_row(8'h00, 8'h00, KEY_HIGH, 8'h00, 1'b1, EV_KEY4));
    directed_rows.push_back(scan_row(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, EV_KEY6));
    directed_rows.push_back(scan_row(KEY_LOW, KEY_LOW, KEY_LOW, KEY_LOW, 1'b1, EV_NONE));
    directed_rows.push_back(scan_row(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, EV_KEY7));
    directed_rows.push_back(scan_row(KEY_HIGH, 8'h00, 8'h00, KEY_HIGH, 1'b1, EV_KEY8));
    directed_rows.push_back(scan_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, EV_NONE));
    // Zero thresholds: immediate long press, repeat on every tick, code on release
    directed_rows.push_back(cfg_row(8'd0, 8'd0, 8'd0));
    directed_rows.push_back(scan_row(KEY_LOW, 8'h00, 8'h00, 8'h00, 1'b1, EV_LONG1));
    directed_rows.push_back(scan_row(KEY_LOW, 8'h00, 8'h00, 8'h00, 1'b1, EV_NONE));
    directed_rows.push_back(scan_row(8'h00, 8'h00, KEY_HIGH, 8'h00, 1'b1, EV_KEY6));
    directed_rows.push_back(scan_row(8'h00, 8'h00, KEY_HIGH, 8'h00, 1'b0, EV_NONE));
    directed_rows.push_back(scan_row(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, EV_KEY6));
    // Maximum thresholds: no repeat start, short codes only
    directed_rows.push_back(cfg_row(8'd255, 8'd255, 8'd255));
    directed_rows.push_back(scan_row(8'h00, 8'h00, KEY_HIGH, KEY_LOW, 1'b1, EV_NONE));
    directed_rows.push_back(scan_row(8'h00, KEY_LOW, 8'h00, 8'h00, 1'b1, EV_KEY7));
    directed_rows.push_back(scan_row(8'h00, 8'h00, 8'h00, 8'h00, 1'b1, EV_KEY3));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        load_thresholds(directed_rows[r].byte0, directed_rows[r].byte1, directed_rows[r].byte2);
      end else begin
        push_scan(directed_rows[r].byte0, directed_rows[r].byte1, directed_rows[r].byte2,
                  directed_rows[r].byte3, directed_rows[r].typed, directed_rows[r].code);
      end
    end

    run_phase(8'd200, 8'd220, 8'd15, 350, 150, 260);
    run_phase(8'd0, 8'd0, 8'd0, 150, 1, 6);
    run_phase(8'd1, 8'd1, 8'd1, 150, 1, 8);
    // long holds here wrap the repeat-key counters
    run_phase(8'd255, 8'd255, 8'd255, 400, 258, 300);
    run_phase(8'd4, 8'd6, 8'd3, 300, 1, 20);
    run_phase(8'd255, 8'd0, 8'd254, 150, 1, 12);
    run_phase(8'($urandom_range(0, 40)), 8'($urandom_range(0, 40)),
              8'($urandom_range(0, 20)), 150, 1, 40);

    wait_drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
